FILE: hdl/ffha_pkg.sv
// ffha_pkg: shared types and codes of the first-fit heap allocator.
// No dependencies; used by the interfaces, the allocator and the testbench.
package ffha_pkg;

  localparam int unsigned REQ_W = 15;
  localparam int unsigned OFF_W = 14;
  localparam int unsigned SPAN_W = 15;
  localparam logic [SPAN_W-1:0] SPAN_RESET = 15'd16384;

  typedef enum logic {
    OP_ALLOC = 1'b0,
    OP_FREE  = 1'b1
  } op_e;

  typedef enum logic [4:0] {
    ST_IDLE,
    ST_INIT,
    ST_A_START,
    ST_A_RD,
    ST_A_CHK,
    ST_A_SPLIT,
    ST_A_LINK,
    ST_A_WCUR,
    ST_F_RED,
    ST_F_RDHB,
    ST_F_HB,
    ST_F_EMPTYW,
    ST_F_RDN,
    ST_F_NX,
    ST_F_RDC,
    ST_F_C,
    ST_F_JOINC,
    ST_F_WC,
    ST_DONE
  } state_e;

endpackage

FILE: hdl/ffha_if.sv
// ffha_if: request and response channels of the heap allocator.
// Depends on ffha_pkg for field widths.
interface ffha_req_if;
  logic                       valid;
  logic                       ready;
  logic                       op;
  logic [ffha_pkg::REQ_W-1:0] req_size;
  logic [ffha_pkg::OFF_W-1:0] free_offset;
  modport source (output valid, op, req_size, free_offset, input ready);
  modport sink (input valid, op, req_size, free_offset, output ready);
endinterface

interface ffha_rsp_if;
  logic                       valid;
  logic                       ready;
  logic [ffha_pkg::OFF_W-1:0] payload_offset;
  logic                       failed;
  modport source (output valid, payload_offset, failed, input ready);
  modport sink (input valid, payload_offset, failed, output ready);
endinterface

FILE: hdl/ffha_hdr_mem.sv
// ffha_hdr_mem: header store, one write and one registered read port.
// No dependencies.
module ffha_hdr_mem #(
  parameter int unsigned DEPTH = 16384,
  parameter int unsigned AW = 14,
  parameter int unsigned DW = 31
) (
  input  logic          clk_i,
  input  logic          we_i,
  input  logic [AW-1:0] waddr_i,
  input  logic [DW-1:0] wdata_i,
  input  logic [AW-1:0] raddr_i,
  output logic [DW-1:0] rdata_o
);

  logic [DW-1:0] mem_q [DEPTH];
  logic [DW-1:0] rdata_q;

  // write port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // registered read port
  always_ff @(posedge clk_i) begin
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

FILE: hdl/first_fit_heap_allocator.sv
// First-fit heap allocator with coalescing. One request item is taken at a
// time: an allocate walks the address-ordered free list, a free walks it to
// its insertion point. Each list step is one header read on the single read
// port of the header memory, and every header update uses its single write
// port. An ignored free writes no header. After the result the block returns
// to its idle state, where the next request is taken. The result item is held
// in an output register, so the next request is taken while it waits. After
// reset or a heap_span write the INIT state writes the initial free block,
// if the span holds one, before requests are accepted.
module first_fit_heap_allocator #(
  parameter int unsigned HEAP_BYTES = 16384,
  parameter int unsigned HEADER_BYTES = 16
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  ffha_req_if.sink                    req_i,
  ffha_rsp_if.source                  rsp_o,
  input  logic                        cfg_we_i,
  input  logic [ffha_pkg::SPAN_W-1:0] cfg_wdata_i
);
  import ffha_pkg::*;

  localparam int unsigned AW = $clog2(HEAP_BYTES);
  localparam int unsigned SW = AW + 1;
  localparam int unsigned CW = ((SW > REQ_W) ? SW : REQ_W) + 1;
  localparam int unsigned HB = HEADER_BYTES;

  typedef struct packed {
    logic [SW-1:0] size;
    logic [AW-1:0] nxt;
    logic          used;
    logic          linked;
  } hdr_t;

  localparam int unsigned DW = $bits(hdr_t);

  state_e state_q, state_d;

  logic [SPAN_W-1:0] span_q;
  logic              init_q;
  logic [AW-1:0]     head_q, head_d;
  logic              empty_q, empty_d;

  logic              op_q;
  logic [REQ_W-1:0]  req_q;
  logic [OFF_W-1:0]  red_q, red_d;
  logic [AW-1:0]     cur_q, cur_d, prev_q, prev_d, hb_q, hb_d, nx_q, nx_d;
  hdr_t              cur_hdr_q, cur_hdr_d, prev_hdr_q, prev_hdr_d, hb_hdr_q, hb_hdr_d;
  logic              has_prev_q, has_prev_d, ahead_q, ahead_d;
  logic [AW:0]       steps_q, steps_d;
  logic [OFF_W-1:0]  pay_q, pay_d;
  logic              fail_q, fail_d;

  logic              out_valid_q;
  logic [OFF_W-1:0]  out_pay_q;
  logic              out_fail_q;

  logic              mem_we;
  logic [AW-1:0]     mem_waddr, mem_raddr;
  hdr_t              mem_wdata;
  logic [DW-1:0]     mem_rdata;
  hdr_t              rd;

  logic              accept;
  logic              out_free;
  logic [SPAN_W-1:0] span_eff;
  logic              span_small;
  logic              cfg_small;

  // header memory
  ffha_hdr_mem #(.DEPTH(HEAP_BYTES), .AW(AW), .DW(DW)) u_mem (
    .clk_i   (clk_i),
    .we_i    (mem_we),
    .waddr_i (mem_waddr),
    .wdata_i (mem_wdata),
    .raddr_i (mem_raddr),
    .rdata_o (mem_rdata)
  );

  assign rd = hdr_t'(mem_rdata);

  // span clamp and empty test
  assign span_eff = (32'(span_q) > HEAP_BYTES) ? SPAN_W'(HEAP_BYTES) : span_q;
  assign span_small = 32'(span_eff) < HB;
  assign cfg_small = (32'(cfg_wdata_i) > HEAP_BYTES) ? (HEAP_BYTES < HB) :
                     (32'(cfg_wdata_i) < HB);

  assign req_i.ready = (state_q == ST_IDLE) && !init_q;
  assign accept = req_i.valid && req_i.ready;
  assign out_free = !out_valid_q || rsp_o.ready;

  // shared compare results
  logic          a_short, f_adv, f_dup, red_hi;
  logic [31:0]   nb_sum;
  logic [AW-1:0] nb;
  logic [31:0]   hb_end, cur_end;
  hdr_t          hb_join, cur_join;

  assign a_short = CW'(rd.size) < CW'(req_q);
  assign nb_sum = 32'(cur_q) + HB + 32'(req_q);
  assign nb = AW'((nb_sum >= HEAP_BYTES) ? nb_sum - HEAP_BYTES : nb_sum);
  assign red_hi = 32'(red_q) >= HEAP_BYTES;
  assign f_adv = rd.linked && (rd.nxt < hb_q);
  assign f_dup = rd.linked && (rd.nxt == hb_q);

  // join of the freed block with the block read at nx_q
  assign hb_end = 32'(hb_q) + HB + 32'(hb_hdr_q.size);
  always_comb begin
    hb_join = hb_hdr_q;
    if (hb_end == 32'(nx_q)) begin
      hb_join.size = SW'(32'(hb_hdr_q.size) + HB + 32'(rd.size));
      hb_join.nxt = rd.nxt;
      hb_join.linked = rd.linked;
    end else begin
      hb_join.nxt = nx_q;
      hb_join.linked = 1'b1;
    end
  end

  // join of the walk block with the freed block
  assign cur_end = 32'(cur_q) + HB + 32'(cur_hdr_q.size);
  always_comb begin
    cur_join = cur_hdr_q;
    if (cur_end == 32'(hb_q)) begin
      cur_join.size = SW'(32'(cur_hdr_q.size) + HB + 32'(hb_hdr_q.size));
      cur_join.nxt = hb_hdr_q.nxt;
      cur_join.linked = hb_hdr_q.linked;
    end else begin
      cur_join.nxt = hb_q;
      cur_join.linked = 1'b1;
    end
  end

  // next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: begin
        if (init_q) begin
          state_d = ST_INIT;
        end else if (accept) begin
          state_d = (op_e'(req_i.op) == OP_ALLOC) ? ST_A_START : ST_F_RED;
        end
      end
      ST_INIT:    state_d = ST_IDLE;
      ST_A_START: state_d = empty_q ? ST_DONE : ST_A_RD;
      ST_A_RD:    state_d = ST_A_CHK;
      ST_A_CHK: begin
        if (a_short) begin
          state_d = (!rd.linked || 32'(steps_q) == HEAP_BYTES) ? ST_DONE : ST_A_RD;
        end else begin
          state_d = (32'(rd.size) >= 32'(req_q) + HB + 1) ? ST_A_SPLIT : ST_A_LINK;
        end
      end
      ST_A_SPLIT: state_d = ST_A_LINK;
      ST_A_LINK:  state_d = ST_A_WCUR;
      ST_A_WCUR:  state_d = ST_DONE;
      ST_F_RED: begin
        if (32'(req_q) == 0) begin
          state_d = ST_DONE;
        end else if (!red_hi) begin
          state_d = (!empty_q && AW'(red_q) == head_q) ? ST_DONE : ST_F_RDHB;
        end
      end
      ST_F_RDHB: state_d = ST_F_HB;
      ST_F_HB: begin
        if (empty_q) begin
          state_d = ST_F_EMPTYW;
        end else if (hb_q < head_q) begin
          state_d = ST_F_RDN;
        end else begin
          state_d = ST_F_RDC;
        end
      end
      ST_F_EMPTYW: state_d = ST_DONE;
      ST_F_RDN:    state_d = ST_F_NX;
      ST_F_NX:     state_d = ahead_q ? ST_DONE : ST_F_JOINC;
      ST_F_RDC:    state_d = ST_F_C;
      ST_F_C: begin
        if (f_adv) begin
          state_d = (32'(steps_q) == HEAP_BYTES) ? ST_DONE : ST_F_RDC;
        end else if (f_dup) begin
          state_d = ST_DONE;
        end else if (rd.linked) begin
          state_d = ST_F_RDN;
        end else begin
          state_d = ST_F_JOINC;
        end
      end
      ST_F_JOINC: state_d = ST_F_WC;
      ST_F_WC:    state_d = ST_DONE;
      ST_DONE:    state_d = out_free ? ST_IDLE : ST_DONE;
      default:    state_d = ST_IDLE;
    endcase
  end

  // datapath and memory control
  always_comb begin
    head_d = head_q;
    empty_d = empty_q;
    red_d = red_q;
    cur_d = cur_q;
    prev_d = prev_q;
    hb_d = hb_q;
    nx_d = nx_q;
    cur_hdr_d = cur_hdr_q;
    prev_hdr_d = prev_hdr_q;
    hb_hdr_d = hb_hdr_q;
    has_prev_d = has_prev_q;
    ahead_d = ahead_q;
    steps_d = steps_q;
    pay_d = pay_q;
    fail_d = fail_q;
    mem_we = 1'b0;
    mem_waddr = cur_q;
    mem_wdata = cur_hdr_q;
    mem_raddr = cur_q;
    case (state_q)
      ST_IDLE: begin
        pay_d = '0;
        fail_d = 1'b0;
        red_d = req_i.free_offset - OFF_W'(HB);
      end
      ST_INIT: begin
        mem_we = !span_small;
        mem_waddr = '0;
        mem_wdata = '{size: SW'(32'(span_eff) - HB), nxt: '0, used: 1'b0, linked: 1'b0};
      end
      ST_A_START: begin
        fail_d = empty_q;
        cur_d = head_q;
        has_prev_d = 1'b0;
        steps_d = '0;
      end
      ST_A_CHK: begin
        if (a_short) begin
          if (!rd.linked || 32'(steps_q) == HEAP_BYTES) begin
            fail_d = 1'b1;
          end
          steps_d = steps_q + 1'b1;
          prev_d = cur_q;
          prev_hdr_d = rd;
          has_prev_d = 1'b1;
          cur_d = rd.nxt;
        end else begin
          cur_hdr_d = rd;
        end
      end
      ST_A_SPLIT: begin
        mem_we = 1'b1;
        mem_waddr = nb;
        mem_wdata = '{size: SW'(32'(cur_hdr_q.size) - 32'(req_q) - HB),
                      nxt: cur_hdr_q.nxt, used: 1'b0, linked: cur_hdr_q.linked};
        cur_hdr_d.size = SW'(req_q);
        cur_hdr_d.nxt = nb;
        cur_hdr_d.linked = 1'b1;
      end
      ST_A_LINK: begin
        if (has_prev_q) begin
          mem_we = 1'b1;
          mem_waddr = prev_q;
          mem_wdata = prev_hdr_q;
          mem_wdata.nxt = cur_hdr_q.nxt;
          mem_wdata.linked = cur_hdr_q.linked;
        end else if (cur_hdr_q.linked) begin
          head_d = cur_hdr_q.nxt;
        end else begin
          empty_d = 1'b1;
        end
      end
      ST_A_WCUR: begin
        mem_we = 1'b1;
        mem_wdata = '{size: cur_hdr_q.size, nxt: '0, used: 1'b1, linked: 1'b0};
        pay_d = OFF_W'(32'(cur_q) + HB);
      end
      ST_F_RED: begin
        if (red_hi) begin
          red_d = red_q - OFF_W'(HEAP_BYTES);
        end
        hb_d = AW'(red_q);
      end
      ST_F_RDHB: begin
        mem_raddr = hb_q;
      end
      ST_F_HB: begin
        hb_hdr_d = rd;
        hb_hdr_d.used = 1'b0;
        cur_d = head_q;
        nx_d = head_q;
        steps_d = '0;
        ahead_d = hb_q < head_q;
      end
      ST_F_EMPTYW: begin
        mem_we = 1'b1;
        mem_waddr = hb_q;
        mem_wdata = '{size: hb_hdr_q.size, nxt: '0, used: 1'b0, linked: 1'b0};
        head_d = hb_q;
        empty_d = 1'b0;
      end
      ST_F_RDN: begin
        mem_raddr = nx_q;
      end
      ST_F_NX: begin
        hb_hdr_d = hb_join;
        if (ahead_q) begin
          mem_we = 1'b1;
          mem_waddr = hb_q;
          mem_wdata = hb_join;
          head_d = hb_q;
        end
      end
      ST_F_C: begin
        cur_hdr_d = rd;
        if (f_adv) begin
          steps_d = steps_q + 1'b1;
          cur_d = rd.nxt;
        end else if (rd.linked) begin
          nx_d = rd.nxt;
        end else begin
          hb_hdr_d.linked = 1'b0;
          hb_hdr_d.nxt = '0;
        end
      end
      ST_F_JOINC: begin
        mem_we = 1'b1;
        mem_waddr = hb_q;
        mem_wdata = hb_hdr_q;
        cur_hdr_d = cur_join;
      end
      ST_F_WC: begin
        mem_we = 1'b1;
      end
      default: begin
      end
    endcase
  end

  // control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      span_q <= SPAN_RESET;
      init_q <= 1'b1;
      head_q <= '0;
      empty_q <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (cfg_we_i) begin
        span_q <= cfg_wdata_i;
        init_q <= 1'b1;
        head_q <= '0;
        empty_q <= cfg_small;
      end else begin
        head_q <= head_d;
        empty_q <= empty_d;
        if (state_q == ST_INIT) begin
          init_q <= 1'b0;
        end
      end
      if (state_q == ST_DONE && out_free) begin
        out_valid_q <= 1'b1;
      end else if (rsp_o.ready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    if (accept) begin
      op_q <= req_i.op;
      req_q <= (op_e'(req_i.op) == OP_ALLOC) ? req_i.req_size :
               REQ_W'(32'(req_i.free_offset) >= HB);
    end
    red_q <= red_d;
    cur_q <= cur_d;
    prev_q <= prev_d;
    hb_q <= hb_d;
    nx_q <= nx_d;
    cur_hdr_q <= cur_hdr_d;
    prev_hdr_q <= prev_hdr_d;
    hb_hdr_q <= hb_hdr_d;
    has_prev_q <= has_prev_d;
    ahead_q <= ahead_d;
    steps_q <= steps_d;
    pay_q <= pay_d;
    fail_q <= fail_d;
    if (state_q == ST_DONE && out_free) begin
      out_pay_q <= (op_e'(op_q) == OP_ALLOC && !fail_q) ? pay_q : '0;
      out_fail_q <= (op_e'(op_q) == OP_ALLOC) && fail_q;
    end
  end

  assign rsp_o.valid = out_valid_q;
  assign rsp_o.payload_offset = out_pay_q;
  assign rsp_o.failed = out_fail_q;

`ifndef SYNTHESIS
  a_ready_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    req_i.ready |-> (state_q == ST_IDLE) && !init_q)
    else $error("ready outside idle");
  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (req_i.valid && req_i.ready) |=> (state_q != ST_IDLE))
    else $error("accepted item not started");
  a_result_from_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_q) |-> $past(state_q) == ST_DONE)
    else $error("result without finished item");
`endif

endmodule

FILE: tb/first_fit_heap_allocator_tb.sv
// Testbench of first_fit_heap_allocator: a directed table, then random phases.
// Phases run under several heap_span values. Depends on ffha_pkg, ffha_if and the RTL.
`timescale 1ns / 100ps

module first_fit_heap_allocator_tb;
  import ffha_pkg::*;

  localparam int unsigned HEAP = 16384;
  localparam int unsigned HDR = 16;

  typedef struct packed {
    logic [OFF_W-1:0] payload_offset;
    logic             failed;
  } rsp_t;

  typedef struct {
    op_e              op;
    logic [REQ_W-1:0] req_size;
    logic [OFF_W-1:0] free_offset;
    bit               typed;
    rsp_t             want;
  } row_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic cfg_we_i;
  logic [SPAN_W-1:0] cfg_wdata_i;

  ffha_req_if req_bus ();
  ffha_rsp_if rsp_bus ();

  first_fit_heap_allocator i_dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .req_i      (req_bus.sink),
    .rsp_o      (rsp_bus.source),
    .cfg_we_i   (cfg_we_i),
    .cfg_wdata_i(cfg_wdata_i)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // Shadow heap
  int unsigned blk_size [HEAP];
  int unsigned blk_next [HEAP];
  bit          blk_used [HEAP];
  bit          blk_linked [HEAP];
  int unsigned head_off;
  bit          heap_empty;
  int unsigned span_reg;

  rsp_t        pending_rsp[$];
  int unsigned live_blocks[$];  // payload offsets of allocated blocks
  int          errs = 0;
  bit          quiet = 1'b0;

  function automatic void shadow_reset();
    int unsigned span;
    span = (span_reg > HEAP) ? HEAP : span_reg;
    for (int i = 0; i < HEAP; i++) begin
      blk_size[i] = 0; blk_next[i] = 0; blk_used[i] = 0; blk_linked[i] = 0;
    end
    head_off = 0;
    heap_empty = (span < HDR);
    if (!heap_empty) blk_size[0] = span - HDR;
  endfunction

  // Chain block a to b, merging when b directly follows a
  function automatic void chain(int unsigned a, int unsigned b);
    if (longint'(a) + HDR + blk_size[a] == longint'(b)) begin
      blk_size[a] += HDR + blk_size[b];
      blk_next[a] = blk_next[b];
      blk_linked[a] = blk_linked[b];
    end else begin
      blk_next[a] = b;
      blk_linked[a] = 1'b1;
    end
  endfunction

  function automatic bit heap_alloc(int unsigned req, output int unsigned pay);
    int unsigned cur, prev, steps, nb;
    bit has_prev;
    prev = 0; steps = 0; has_prev = 0; pay = 0;
    if (heap_empty) return 0;
    cur = head_off;
    while (blk_size[cur] < req) begin
      if (!blk_linked[cur]) return 0;
      steps++;
      if (steps > HEAP) return 0;
      prev = cur; has_prev = 1;
      cur = blk_next[cur];
    end
    if (blk_size[cur] - req >= HDR + 1) begin
      nb = (cur + HDR + req) % HEAP;
      blk_size[nb] = blk_size[cur] - req - HDR;
      blk_used[nb] = 0;
      blk_next[nb] = blk_next[cur];
      blk_linked[nb] = blk_linked[cur];
      blk_size[cur] = req;
      blk_next[cur] = nb;
      blk_linked[cur] = 1;
    end
    if (has_prev) begin
      blk_next[prev] = blk_next[cur];
      blk_linked[prev] = blk_linked[cur];
    end else if (blk_linked[cur]) head_off = blk_next[cur];
    else heap_empty = 1;
    blk_used[cur] = 1; blk_linked[cur] = 0; blk_next[cur] = 0;
    pay = cur + HDR;
    return 1;
  endfunction

  function automatic void heap_free(int unsigned off);
    int unsigned hb, cur, steps;
    steps = 0;
    if (off < HDR) return;
    hb = (off - HDR) % HEAP;
    if (heap_empty) begin
      blk_used[hb] = 0; blk_linked[hb] = 0; blk_next[hb] = 0;
      head_off = hb; heap_empty = 0;
      return;
    end
    if (hb == head_off) return;
    if (hb < head_off) begin
      blk_used[hb] = 0;
      chain(hb, head_off);
      head_off = hb;
      return;
    end
    cur = head_off;
    while (blk_linked[cur] && blk_next[cur] < hb) begin
      steps++;
      if (steps > HEAP) return;
      cur = blk_next[cur];
    end
    if (blk_linked[cur] && blk_next[cur] == hb) return;
    blk_used[hb] = 0;
    if (blk_linked[cur]) chain(hb, blk_next[cur]);
    else begin
      blk_linked[hb] = 0; blk_next[hb] = 0;
    end
    chain(cur, hb);
  endfunction

  // Predicted response of one accepted item; also tracks live blocks
  function automatic rsp_t heap_step(op_e op, int unsigned req, int unsigned off);
    rsp_t r;
    int unsigned pay;
    r = '0;
    if (op == OP_ALLOC) begin
      if (heap_alloc(req, pay)) begin
        r.payload_offset = pay[OFF_W-1:0];
        live_blocks.push_back(pay);
      end else r.failed = 1'b1;
    end else begin
      foreach (live_blocks[i]) if (live_blocks[i] == off) begin
        live_blocks.delete(i);
        break;
      end
      heap_free(off);
    end
    return r;
  endfunction

  // Drive one request item and wait for its acceptance
  task automatic send_item(op_e op, logic [REQ_W-1:0] req, logic [OFF_W-1:0] off,
                           bit typed = 0, rsp_t want = '0);
    rsp_t r;
    if (!quiet && $urandom_range(0, 3) == 0) begin
      req_bus.valid <= 1'b0;
      repeat ($urandom_range(1, 13)) @(posedge clk_i);
    end
    req_bus.valid <= 1'b1;
    req_bus.op <= op;
    req_bus.req_size <= req;
    req_bus.free_offset <= off;
    do @(posedge clk_i); while (!req_bus.ready);
    r = heap_step(op, req, off);
    if (typed && r != want) begin
      $error("table row disagrees with predictor: want %h got %h", want, r);
      errs++;
    end
    pending_rsp.push_back(typed ? want : r);
  endtask

  task automatic write_span(logic [SPAN_W-1:0] v);
    req_bus.valid <= 1'b0;
    @(posedge clk_i);
    while (pending_rsp.size() > 0) @(posedge clk_i);
    repeat (20) @(posedge clk_i);
    cfg_we_i <= 1'b1;
    cfg_wdata_i <= v;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    span_reg = v;
    shadow_reset();
    live_blocks.delete();
  endtask

  // Random phase: mostly alloc/free of live blocks, some noise
  task automatic random_phase(int n, int unsigned max_req);
    int unsigned k, off;
    for (int i = 0; i < n; i++) begin
      k = $urandom_range(0, 99);
      if (k < 5) send_item(OP_ALLOC, REQ_W'($urandom), OFF_W'($urandom));
      else if (k < 8) send_item(OP_FREE, REQ_W'($urandom), OFF_W'($urandom_range(0, HDR - 1)));
      else if (k < 11 && !heap_empty)
        send_item(OP_FREE, REQ_W'($urandom), OFF_W'(head_off + HDR));
      else if (k < 55 && live_blocks.size() > 0) begin
        off = live_blocks[$urandom_range(0, live_blocks.size() - 1)];
        send_item(OP_FREE, REQ_W'($urandom), OFF_W'(off));
      end else
        send_item(OP_ALLOC, REQ_W'($urandom_range(0, max_req)), OFF_W'($urandom));
    end
  endtask

  // Response stall bursts
  int unsigned stall_left = 0;
  always @(posedge clk_i) begin
    if (stall_left > 0) begin
      stall_left <= stall_left - 1;
      rsp_bus.ready <= 1'b0;
    end else if (!quiet && $urandom_range(0, 4) == 0) begin
      stall_left <= $urandom_range(1, 13) - 1;
      rsp_bus.ready <= 1'b0;
    end else rsp_bus.ready <= 1'b1;
  end

  // Response check against the oldest expectation
  always @(posedge clk_i) begin
    rsp_t w;
    if (rst_ni && rsp_bus.valid && rsp_bus.ready) begin
      if (pending_rsp.size() == 0) begin
        $error("response with no request outstanding");
        errs++;
      end else begin
        w = pending_rsp.pop_front();
        if (rsp_bus.payload_offset !== w.payload_offset) begin
          $error("payload_offset: expected %0d actual %0d", w.payload_offset,
                 rsp_bus.payload_offset);
          errs++;
        end
        if (rsp_bus.failed !== w.failed) begin
          $error("failed: expected %0d actual %0d", w.failed, rsp_bus.failed);
          errs++;
        end
      end
    end
  end

  initial begin
    #100ms;
    $display("** first_fit_heap_allocator: FAILED **");
    $finish;
  end

  // Directed table, reset span; typed rows follow from the full-heap layout
  row_t dir_rows[$] = '{
    '{OP_ALLOC, 15'd16351, 14'd0,     1'b1, '{14'd16, 1'b0}},
    '{OP_FREE,  15'd0,     14'd16383, 1'b1, '{14'd0, 1'b0}},     // free of list head
    '{OP_ALLOC, 15'd1,     14'd0,     1'b1, '{14'd16383, 1'b0}},
    '{OP_ALLOC, 15'd0,     14'd0,     1'b1, '{14'd0, 1'b1}},     // list empty
    '{OP_FREE,  15'd0,     14'd16,    1'b1, '{14'd0, 1'b0}},     // into empty list
    '{OP_FREE,  15'd0,     14'd16383, 1'b1, '{14'd0, 1'b0}},     // merges back
    '{OP_ALLOC, 15'd32767, 14'd0,     1'b1, '{14'd0, 1'b1}},
    '{OP_ALLOC, 15'd16369, 14'd0,     1'b1, '{14'd0, 1'b1}},
    '{OP_ALLOC, 15'd16368, 14'd0,     1'b1, '{14'd16, 1'b0}},
    '{OP_FREE,  15'd0,     14'd16,    1'b0, '{14'd0, 1'b0}},
    '{OP_FREE,  15'd0,     14'd5,     1'b1, '{14'd0, 1'b0}},     // below header
    '{OP_ALLOC, 15'd0,     14'd0,     1'b1, '{14'd16, 1'b0}},    // zero request
    '{OP_ALLOC, 15'd100,   14'd0,     1'b0, '{14'd0, 1'b0}},
    '{OP_ALLOC, 15'd200,   14'd0,     1'b0, '{14'd0, 1'b0}},
    '{OP_ALLOC, 15'd50,    14'd0,     1'b0, '{14'd0, 1'b0}},
    '{OP_FREE,  15'd0,     14'd32,    1'b0, '{14'd0, 1'b0}},
    '{OP_FREE,  15'd0,     14'd16,    1'b0, '{14'd0, 1'b0}},     // ahead of head
    '{OP_FREE,  15'd0,     14'd148,   1'b0, '{14'd0, 1'b0}},
    '{OP_ALLOC, 15'd40,    14'd0,     1'b0, '{14'd0, 1'b0}}
  };

  initial begin
    req_bus.valid <= 1'b0;
    req_bus.op <= OP_ALLOC;
    req_bus.req_size <= '0;
    req_bus.free_offset <= '0;
    cfg_we_i <= 1'b0;
    cfg_wdata_i <= '0;
    span_reg = SPAN_RESET;
    shadow_reset();
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (dir_rows[i])
      send_item(dir_rows[i].op, dir_rows[i].req_size, dir_rows[i].free_offset,
                dir_rows[i].typed, dir_rows[i].want);
    random_phase(120, 700);

    write_span(15'd256);
    random_phase(90, 120);
    write_span(15'd16);   // one block of size zero
    random_phase(20, 3);
    write_span(15'd0);    // empty list from the start
    random_phase(20, 5);
    write_span(15'd32767); // clamped to the heap size
    random_phase(110, 900);
    write_span(15'($urandom_range(17, 3000)));
    random_phase(100, 300);
    write_span(15'd16384);
    quiet = 1'b1;
    random_phase(170, 500);

    req_bus.valid <= 1'b0;
    while (pending_rsp.size() > 0) @(posedge clk_i);
    repeat (50) @(posedge clk_i);
    if (errs == 0) begin
      $display("** first_fit_heap_allocator: PASSED **");
    end else begin
      $display("** first_fit_heap_allocator: FAILED **");
    end
    $finish;
  end

endmodule

FILE: filelist.f
hdl/ffha_pkg.sv
hdl/ffha_if.sv
hdl/ffha_hdr_mem.sv
hdl/first_fit_heap_allocator.sv
tb/first_fit_heap_allocator_tb.sv
